### hw/rtl/pocm_pkg.sv
`timescale 1ns / 1ps

package pocm_pkg;

  // Coordinate width default, and fixed widths of the remaining fields
  localparam int COORD_BITS_DEF = 13;
  localparam int SIDE_BITS      = 12;
  localparam int COUNT_BITS     = 8;
  localparam int DATA_BITS      = 32;
  localparam int ADDR_BITS      = 4;
  localparam int REG_SEL_BITS   = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 8'd255;

  // Register indexes (paddr[3:2])
  localparam logic [REG_SEL_BITS-1:0] REG_HEIGHT = 2'd0;
  localparam logic [REG_SEL_BITS-1:0] REG_WIDTH  = 2'd1;
  localparam logic [REG_SEL_BITS-1:0] REG_SIDE   = 2'd2;
  localparam logic [REG_SEL_BITS-1:0] REG_STEP   = 2'd3;

  // Register values after reset
  localparam int HEIGHT_RESET = 1024;
  localparam int WIDTH_RESET  = 1024;
  localparam int SIDE_RESET   = 256;
  localparam int STEP_RESET   = 230;

endpackage

### hw/rtl/patch_overlap_count_mask.sv
`timescale 1ns / 1ps
// Pipeline: set-up stage, restoring divider stages, count stage and output stage, start to done.
// Throughput: one pixel per cycle; the stride divisions run as a pipelined restoring
// divider, one quotient bit per stage, so every stage takes a new pixel each cycle.
// Reset: synchronous, clears all stage valids and done, holds busy high as a registered
// copy of rst, and loads height 1024, width 1024, patch 256, step 230.
// Results are strobed on done for one cycle; the receiver cannot stall.
module patch_overlap_count_mask #(
  parameter int COORD_BITS = pocm_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // command channel
  input  logic                            start,
  output logic                            busy,
  input  logic [COORD_BITS-1:0]           pixel_row,
  input  logic [COORD_BITS-1:0]           pixel_col,
  // result channel
  output logic                            done,
  output logic [pocm_pkg::COUNT_BITS-1:0] cover_count,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pocm_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [pocm_pkg::DATA_BITS-1:0]  pwdata,
  output logic [pocm_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready
);
  import pocm_pkg::*;

  // Working width covers both coordinates and patch side
  localparam int WB = (COORD_BITS > SIDE_BITS) ? COORD_BITS : SIDE_BITS;
  localparam int CB = WB + 1;

  typedef struct packed {
    logic                 fit;       // a regular patch fits on this axis
    logic                 has_lo;    // position at or past one patch side
    logic                 edge_hit;  // edge interval covers position
    logic [WB-1:0]        hi_word;   // dividend, becomes kmax
    logic [WB-1:0]        lo_word;   // dividend, becomes kmin - 1
    logic [SIDE_BITS-1:0] hi_rem;
    logic [SIDE_BITS-1:0] lo_rem;
  } axis_t;

  typedef struct packed {
    logic  in_img;
    axis_t r;
    axis_t c;
  } item_t;

  // Configuration registers
  logic [COORD_BITS-1:0] image_height;
  logic [COORD_BITS-1:0] image_width;
  logic [SIDE_BITS-1:0]  patch_side;
  logic [SIDE_BITS-1:0]  step_size;
  logic [SIDE_BITS-1:0]  step_eff;
  logic                  cfg_wr;

  // Pipeline
  item_t           stg      [0:WB];
  item_t           stg_next [1:WB];
  logic [WB:0]     vld;
  item_t           prep;
  logic            cnt_vld;
  logic            cnt_inside;
  logic [CB-1:0]   row_cnt;
  logic [CB-1:0]   col_cnt;
  logic [2*CB-1:0] prod;
  logic            take_item;

  // One restoring division step: shift in dividend MSB, shift out quotient bit
  function automatic logic [SIDE_BITS+WB-1:0] div_step(
    input logic [SIDE_BITS-1:0] rem,
    input logic [WB-1:0]        word,
    input logic [SIDE_BITS-1:0] dvs
  );
    logic [SIDE_BITS:0]   trial;
    logic                 take;
    logic [SIDE_BITS-1:0] rem_n;
    trial = {rem, word[WB-1]};
    take  = (trial >= {1'b0, dvs});
    rem_n = take ? SIDE_BITS'(trial - {1'b0, dvs}) : trial[SIDE_BITS-1:0];
    return {rem_n, word[WB-2:0], take};
  endfunction

  // Per-axis set-up ahead of the divider
  function automatic axis_t axis_prep(
    input logic [WB-1:0] pos,
    input logic [WB-1:0] len,
    input logic [WB-1:0] side
  );
    axis_t         a;
    logic [WB-1:0] lim;
    a.fit      = (len > side);
    lim        = len - side - WB'(1);
    a.has_lo   = (pos >= side);
    a.hi_word  = (pos < lim) ? pos : lim;
    a.lo_word  = pos - side;
    a.edge_hit = (side != '0) && (!a.fit || (pos >= len - side));
    a.hi_rem   = '0;
    a.lo_rem   = '0;
    return a;
  endfunction

  // Intervals covering the position: regular span plus edge
  function automatic logic [CB-1:0] axis_total(input axis_t a);
    logic [CB-1:0] kmax;
    logic [CB-1:0] kmin;
    logic [CB-1:0] regular;
    kmax    = {1'b0, a.hi_word};
    kmin    = a.has_lo ? ({1'b0, a.lo_word} + CB'(1)) : '0;
    regular = (a.fit && (kmax >= kmin)) ? (kmax - kmin + CB'(1)) : '0;
    return regular + CB'(a.edge_hit);
  endfunction

  // APB register file
  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite;
  assign step_eff  = (step_size == '0) ? SIDE_BITS'(1) : step_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_height <= COORD_BITS'(HEIGHT_RESET);
      image_width  <= COORD_BITS'(WIDTH_RESET);
      patch_side   <= SIDE_BITS'(SIDE_RESET);
      step_size    <= SIDE_BITS'(STEP_RESET);
    end else if (cfg_wr) begin
      case (paddr[ADDR_BITS-1:2])
        REG_HEIGHT: image_height <= pwdata[COORD_BITS-1:0];
        REG_WIDTH:  image_width  <= pwdata[COORD_BITS-1:0];
        REG_SIDE:   patch_side   <= pwdata[SIDE_BITS-1:0];
        REG_STEP:   step_size    <= pwdata[SIDE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_BITS-1:2])
      REG_HEIGHT: prdata = DATA_BITS'(image_height);
      REG_WIDTH:  prdata = DATA_BITS'(image_width);
      REG_SIDE:   prdata = DATA_BITS'(patch_side);
      REG_STEP:   prdata = DATA_BITS'(step_size);
      default:    prdata = '0;
    endcase
  end

  // Command handshake
  assign take_item = start & ~busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Stage 0: bounds test and axis set-up
  always_comb begin
    prep.in_img = (pixel_row < image_height) && (pixel_col < image_width);
    prep.r = axis_prep(WB'(pixel_row), WB'(image_height), WB'(patch_side));
    prep.c = axis_prep(WB'(pixel_col), WB'(image_width), WB'(patch_side));
  end

  // Divider stages: four divisions by the step in lockstep
  always_comb begin
    for (int k = 1; k <= WB; k++) begin
      stg_next[k].in_img     = stg[k-1].in_img;
      stg_next[k].r          = stg[k-1].r;
      stg_next[k].c          = stg[k-1].c;
      {stg_next[k].r.hi_rem, stg_next[k].r.hi_word} =
        div_step(stg[k-1].r.hi_rem, stg[k-1].r.hi_word, step_eff);
      {stg_next[k].r.lo_rem, stg_next[k].r.lo_word} =
        div_step(stg[k-1].r.lo_rem, stg[k-1].r.lo_word, step_eff);
      {stg_next[k].c.hi_rem, stg_next[k].c.hi_word} =
        div_step(stg[k-1].c.hi_rem, stg[k-1].c.hi_word, step_eff);
      {stg_next[k].c.lo_rem, stg_next[k].c.lo_word} =
        div_step(stg[k-1].c.lo_rem, stg[k-1].c.lo_word, step_eff);
    end
  end

  always_ff @(posedge clk) begin
    stg[0] <= prep;
    for (int k = 1; k <= WB; k++) begin
      stg[k] <= stg_next[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[WB-1:0], take_item};
    end
  end

  // Count stage: per-axis covers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= 1'b0;
    end else begin
      cnt_vld <= vld[WB];
    end
    cnt_inside <= stg[WB].in_img;
    row_cnt    <= axis_total(stg[WB].r);
    col_cnt    <= axis_total(stg[WB].c);
  end

  // Output stage: product, saturation, and zero for pixels outside the image
  assign prod = row_cnt * col_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cnt_vld;
    end
    if (!cnt_inside) begin
      cover_count <= '0;
    end else if (prod > (2*CB)'(COUNT_MAX)) begin
      cover_count <= COUNT_MAX;
    end else begin
      cover_count <= prod[COUNT_BITS-1:0];
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pocm_pkg::*;

  localparam int CB          = COORD_BITS_DEF;
  localparam int LATENCY     = ((CB > SIDE_BITS) ? CB : SIDE_BITS) + 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 150;

  typedef struct packed {
    logic [CB-1:0] row;
    logic [CB-1:0] col;
  } pixel_t;

  typedef struct packed {
    logic [CB-1:0]         row;
    logic [CB-1:0]         col;
    logic [COUNT_BITS-1:0] count;
  } cover_expect_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [CB-1:0]         pixel_row = '0;
  logic [CB-1:0]         pixel_col = '0;
  logic                  done;
  logic [COUNT_BITS-1:0] cover_count;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_BITS-1:0]  paddr = '0;
  logic [DATA_BITS-1:0]  pwdata = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;

  // Local copy of the configuration registers
  logic [CB-1:0]        cfg_height = CB'(HEIGHT_RESET);
  logic [CB-1:0]        cfg_width  = CB'(WIDTH_RESET);
  logic [SIDE_BITS-1:0] cfg_side   = SIDE_BITS'(SIDE_RESET);
  logic [SIDE_BITS-1:0] cfg_step   = SIDE_BITS'(STEP_RESET);

  pixel_t        pixel_queue[$];
  cover_expect_t cover_queue[$];

  bit          item_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned saturated_seen = 0;
  int unsigned zero_seen = 0;
  int unsigned phase_count = 0;
  int unsigned fault_count = 0;

  patch_overlap_count_mask dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .pixel_row   (pixel_row),
    .pixel_col   (pixel_col),
    .done        (done),
    .cover_count (cover_count),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Intervals on one axis that cover pos: regular origins at multiples of the
  // step that still fit, plus the edge interval ending at the last pixel
  function automatic int unsigned axis_cover(int unsigned pos, int unsigned len,
                                             int unsigned side, int unsigned step);
    int unsigned regular;
    int unsigned edge_hit;
    int unsigned lim;
    int unsigned hi;
    int unsigned kmax;
    int unsigned kmin;
    regular = 0;
    if (len > side) begin
      lim  = len - side - 1;
      hi   = (pos < lim) ? pos : lim;
      kmax = hi / step;
      kmin = (pos >= side) ? ((pos - side) / step + 1) : 0;
      if (kmax >= kmin) regular = kmax - kmin + 1;
      edge_hit = (side != 0 && pos >= len - side) ? 1 : 0;
    end else begin
      // patch wider than the axis: only the clamped edge interval remains
      edge_hit = (side != 0) ? 1 : 0;
    end
    return regular + edge_hit;
  endfunction

  // Expected count for one pixel under the current register settings
  function automatic logic [COUNT_BITS-1:0] predict_cover(logic [CB-1:0] row,
                                                          logic [CB-1:0] col);
    int unsigned step;
    int unsigned total;
    step  = (cfg_step == '0) ? 1 : 32'(cfg_step);
    total = 0;
    if (row < cfg_height && col < cfg_width) begin
      total = axis_cover(32'(row), 32'(cfg_height), 32'(cfg_side), step) *
              axis_cover(32'(col), 32'(cfg_width), 32'(cfg_side), step);
      if (total > 32'(COUNT_MAX)) total = 32'(COUNT_MAX);
    end
    return total[COUNT_BITS-1:0];
  endfunction

  // Monitor: record accepted transactions and check strobed results
  always @(posedge clk) begin : monitor_blk
    cover_expect_t exp_item;
    if (!rst) begin
      if (done) begin
        if (cover_queue.size() == 0) begin
          fault_count++;
          $display("%0t: unexpected result, cover_count %0d", $time, cover_count);
        end else begin
          exp_item = cover_queue.pop_front();
          results_checked++;
          if (exp_item.count == COUNT_MAX) saturated_seen++;
          if (exp_item.count == '0) zero_seen++;
          if (cover_count !== exp_item.count) begin
            fault_count++;
            $display("%0t: cover_count mismatch at row %0d col %0d: expected %0d, got %0d",
                     $time, exp_item.row, exp_item.col, exp_item.count, cover_count);
          end
        end
      end
      item_taken = start && !busy;
      if (item_taken) begin
        exp_item.row   = pixel_row;
        exp_item.col   = pixel_col;
        exp_item.count = predict_cover(pixel_row, pixel_col);
        cover_queue.push_back(exp_item);
        items_sent++;
      end
    end else begin
      item_taken = 1'b0;
    end
  end

  // Driver: bursts of transactions with random gaps in between
  always @(negedge clk) begin : driver_blk
    pixel_t nxt;
    bit     go;
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !item_taken)) begin
      go = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pixel_queue.size() > 0) begin
        nxt = pixel_queue.pop_front();
        go  = 1'b1;
        if (burst_left <= 1) begin
          // occasionally a long stretch without any idling
          burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
      start <= go;
      if (go) begin
        pixel_row <= nxt.row;
        pixel_col <= nxt.col;
      end
    end
  end

  // Cycle limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  task automatic reg_read_check(logic [REG_SEL_BITS-1:0] idx, int unsigned want);
    logic [DATA_BITS-1:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== want) begin
      fault_count++;
      $display("%0t: register %0d readback: expected %0d, got %0d", $time, idx, want, rd);
    end
  endtask

  // One register write, mirrored into the local copy, then read back
  task automatic reg_write(logic [REG_SEL_BITS-1:0] idx, int unsigned value);
    int unsigned want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_HEIGHT: cfg_height = value[CB-1:0];
      REG_WIDTH:  cfg_width  = value[CB-1:0];
      REG_SIDE:   cfg_side   = value[SIDE_BITS-1:0];
      REG_STEP:   cfg_step   = value[SIDE_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_HEIGHT: want = 32'(cfg_height);
      REG_WIDTH:  want = 32'(cfg_width);
      REG_SIDE:   want = 32'(cfg_side);
      default:    want = 32'(cfg_step);
    endcase
    reg_read_check(idx, want);
  endtask

  task automatic set_geometry(int unsigned h, int unsigned w, int unsigned side,
                              int unsigned step);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_WIDTH, w);
    reg_write(REG_SIDE, side);
    reg_write(REG_STEP, step);
    phase_count++;
  endtask

  task automatic queue_pixel(int unsigned row, int unsigned col);
    pixel_t p;
    p.row = row[CB-1:0];
    p.col = col[CB-1:0];
    pixel_queue.push_back(p);
  endtask

  // Wait until every queued transaction is accepted and answered, then let
  // the pipeline run empty before touching the registers again
  task automatic wait_idle();
    while (pixel_queue.size() != 0 || start || cover_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // Stimulus sequence
  initial begin : stim_blk
    int unsigned kind;
    int unsigned h;
    int unsigned w;
    int unsigned side;
    int unsigned step;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers must come up at their reset values
    reg_read_check(REG_HEIGHT, HEIGHT_RESET);
    reg_read_check(REG_WIDTH, WIDTH_RESET);
    reg_read_check(REG_SIDE, SIDE_RESET);
    reg_read_check(REG_STEP, STEP_RESET);

    // reset geometry: corners, just outside, field extremes
    phase_count++;
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    queue_pixel(1024, 0);
    queue_pixel(0, 1024);
    queue_pixel(8191, 8191);
    queue_pixel(229, 231);
    queue_pixel(767, 768);
    wait_idle();

    // largest image, dense patches: saturation
    set_geometry(8191, 8191, 4095, 1);
    queue_pixel(4095, 4095);
    queue_pixel(8190, 8190);
    queue_pixel(0, 8190);
    wait_idle();

    // small tiling, edges and interior
    set_geometry(20, 17, 5, 3);
    queue_pixel(0, 0);
    queue_pixel(19, 16);
    queue_pixel(14, 11);
    queue_pixel(15, 12);
    queue_pixel(7, 8);
    wait_idle();

    // zero step behaves as a step of one
    set_geometry(10, 10, 4, 0);
    queue_pixel(3, 6);
    queue_pixel(9, 9);
    wait_idle();

    // zero patch side covers nothing
    set_geometry(10, 10, 0, 3);
    queue_pixel(2, 2);
    wait_idle();

    // patch taller than the image on the row axis
    set_geometry(5, 300, 64, 7);
    queue_pixel(4, 299);
    queue_pixel(2, 100);
    wait_idle();

    // empty image
    set_geometry(0, 0, 1, 1);
    queue_pixel(0, 0);
    wait_idle();

    // one-pixel image
    set_geometry(1, 1, 1, 1);
    queue_pixel(0, 0);
    queue_pixel(1, 0);
    wait_idle();

    // random geometries, mostly small so that counts stay interesting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      kind = (ph < 2) ? ph : $urandom_range(0, 9);
      if (kind == 0) begin
        h    = $urandom_range(1, 8191);
        w    = $urandom_range(1, 8191);
        side = $urandom_range(0, 4095);
        step = $urandom_range(0, 4095);
      end else if (kind == 1) begin
        h    = $urandom & 32'h1FFF;
        w    = $urandom & 32'h1FFF;
        side = $urandom & 32'hFFF;
        step = $urandom & 32'hFFF;
      end else begin
        h    = $urandom_range(1, 80);
        w    = $urandom_range(1, 80);
        side = $urandom_range(1, 40);
        step = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, side + 3);
      end
      set_geometry(h, w, side, step);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (h == 0 || w == 0 || $urandom_range(0, 99) < 15) begin
          queue_pixel($urandom & 32'h1FFF, $urandom & 32'h1FFF);
        end else begin
          queue_pixel($urandom_range(0, h - 1), $urandom_range(0, w - 1));
        end
      end
      wait_idle();
    end

    // stray results after the last expectation would show up here
    repeat (2 * LATENCY + 8) @(negedge clk);
    if (cover_queue.size() != 0) begin
      fault_count++;
      $display("%0t: %0d results never arrived", $time, cover_queue.size());
    end

    $display("Covered %0d geometries, %0d pixel queries, %0d results checked",
             phase_count, items_sent, results_checked);
    $display("Saturated counts: %0d, zero counts: %0d, failures: %0d",
             saturated_seen, zero_seen, fault_count);
    if (fault_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
